[hw/rtl/cfpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpa_pkg
// Shared types and constants for the consensus-filtered position average.
// ----------------------------------------------------------------------------
package cfpa_pkg;

    localparam int Window   = 20;
    localparam int IdxW     = $clog2(Window + 1);
    localparam int SumW     = 32 + $clog2(Window) + 1;

    localparam logic [15:0] ChangeThrRst = 16'd66;
    localparam logic [15:0] AgreeThrRst  = 16'd3277;
    localparam logic [6:0]  MinAgreeRst  = 7'd15;

    localparam logic [1:0] RegChange = 2'd0;
    localparam logic [1:0] RegAgree  = 2'd1;
    localparam logic [1:0] RegMin    = 2'd2;

    typedef struct packed {
        logic signed [31:0] sample_x;
        logic signed [31:0] sample_y;
        logic signed [31:0] sample_z;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] mean_x;
        logic signed [31:0] mean_y;
        logic signed [31:0] mean_z;
        logic [6:0]         used_count;
    } result_t;

    // control from the sequencer to the cell row
    typedef struct packed {
        logic load;   // shift a new sample in at the head
        logic rotate; // circulate the ring by one place
        logic clear;  // clear match counters
        logic count;  // compare each cell with the broadcast z
    } cell_ctl_t;

endpackage

[hw/rtl/consensus_filtered_position_average.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// consensus_filtered_position_average
// Windowed z-consensus filter with per-axis mean of agreeing samples.
// ----------------------------------------------------------------------------
//  channel | dir | payload  | handshake
//  s_      | in  | sample_t | s_valid / s_ready
//  m_      | out | result_t | m_valid / m_ready
//  apb     | in  | 3 regs   | psel / penable, pready tied high
//
// a sample that does not fill the window only loads the ring, if it is taken
// the filling sample starts a pass: ring rotation for the match counts,
// accumulation of the agreeing samples, then three bit-serial divides
// (none when no sample agrees enough)
// reset is synchronous and needs no clearing pass
// a held result stalls only the next window's final sample
module consensus_filtered_position_average (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cfpa_pkg::sample_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cfpa_pkg::result_t  m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import cfpa_pkg::*;

    localparam int CntW = $clog2(Window + 1);

    typedef enum logic [2:0] {
        ST_FILL, ST_MATCH, ST_SUM, ST_DIV, ST_OUT
    } state_t;

    state_t          state_reg;
    logic [15:0]     chg_reg, agr_reg;
    logic [6:0]      min_reg;
    logic [IdxW-1:0] fill_reg;
    logic [CntW-1:0] step_reg;
    logic signed [31:0] last_z_reg;
    logic signed [SumW-1:0] sx_reg, sy_reg, sz_reg;
    logic [6:0]      used_reg;
    logic [1:0]      axis_reg;
    logic signed [31:0] qx_reg, qy_reg;
    result_t         res_reg;
    logic            mv_reg;
    logic            div_start;
    logic            div_done;
    logic signed [31:0] div_q;
    logic signed [SumW-1:0] div_a;

    cell_ctl_t       ctl;
    sample_t         cell_d [Window];
    logic [6:0]      cell_m [Window];
    sample_t         head_in;

    logic            accept;
    logic signed [32:0] zd;
    logic [32:0]     zdist;
    logic            take;
    logic            wr;

    // ring: cell 0 is loaded from input, or from the tail when rotating
    assign head_in = ctl.load ? s_data : cell_d[Window-1];

    for (genvar g = 0; g < Window; g++) begin : g_cell
        cfpa_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .prev_in   (g == 0 ? head_in : cell_d[(g + Window - 1) % Window]),
            .prev_match(cell_m[(g + Window - 1) % Window]),
            .bcast_z   (cell_d[Window-1].sample_z),
            .agree_thr (agr_reg),
            .data_out  (cell_d[g]),
            .match_out (cell_m[g])
        );
    end

    assign zd    = {s_data.sample_z[31], s_data.sample_z} - {last_z_reg[31], last_z_reg};
    assign zdist = zd[32] ? 33'(-zd) : zd;
    assign take  = (fill_reg == '0) || (zdist > {17'd0, chg_reg});

    // the final sample waits until the previous result is gone
    assign s_ready = (state_reg == ST_FILL) &&
                     !(mv_reg && fill_reg == IdxW'(Window - 1));
    assign accept  = s_valid && s_ready;

    always_comb begin
        ctl        = '0;
        ctl.load   = accept && take;
        ctl.clear  = accept && take && fill_reg == IdxW'(Window - 1);
        ctl.rotate = (state_reg == ST_MATCH) || (state_reg == ST_SUM);
        ctl.count  = (state_reg == ST_MATCH);
    end

    assign div_a = (axis_reg == 2'd0) ? sx_reg : (axis_reg == 2'd1) ? sy_reg : sz_reg;

    cfpa_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_a),
        .divisor (used_reg),
        .done    (div_done),
        .quotient(div_q)
    );

    assign wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
            chg_reg   <= ChangeThrRst;
            agr_reg   <= AgreeThrRst;
            min_reg   <= MinAgreeRst;
            fill_reg  <= '0;
            step_reg  <= '0;
            mv_reg    <= 1'b0;
            div_start <= 1'b0;
            axis_reg  <= 2'd0;
        end else begin
            div_start <= 1'b0;
            if (wr) begin
                unique case (paddr[3:2])
                    RegChange: chg_reg <= pwdata[15:0];
                    RegAgree:  agr_reg <= pwdata[15:0];
                    RegMin:    min_reg <= pwdata[6:0];
                    default: ;
                endcase
            end
            if (mv_reg && m_ready) begin
                mv_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_FILL: begin
                    if (accept && take) begin
                        last_z_reg <= s_data.sample_z;
                        if (fill_reg == IdxW'(Window - 1)) begin
                            fill_reg  <= '0;
                            step_reg  <= '0;
                            state_reg <= ST_MATCH;
                        end else begin
                            fill_reg <= fill_reg + IdxW'(1);
                        end
                    end
                end
                ST_MATCH: begin
                    if (step_reg == CntW'(Window - 1)) begin
                        step_reg  <= '0;
                        sx_reg    <= '0;
                        sy_reg    <= '0;
                        sz_reg    <= '0;
                        used_reg  <= 7'd0;
                        state_reg <= ST_SUM;
                    end else begin
                        step_reg <= step_reg + CntW'(1);
                    end
                end
                ST_SUM: begin
                    // tail cell is the one leaving; its counter rotates too
                    if (cell_m[Window-1] >= min_reg) begin
                        sx_reg   <= sx_reg + SumW'(cell_d[Window-1].sample_x);
                        sy_reg   <= sy_reg + SumW'(cell_d[Window-1].sample_y);
                        sz_reg   <= sz_reg + SumW'(cell_d[Window-1].sample_z);
                        used_reg <= used_reg + 7'd1;
                    end
                    if (step_reg == CntW'(Window - 1)) begin
                        state_reg <= ST_DIV;
                        axis_reg  <= 2'd0;
                        div_start <= 1'b1;
                    end else begin
                        step_reg <= step_reg + CntW'(1);
                    end
                end
                ST_DIV: begin
                    if (used_reg == 7'd0) begin
                        state_reg <= ST_OUT;
                        div_start <= 1'b0;
                    end else if (div_done) begin
                        unique case (axis_reg)
                            2'd0: qx_reg <= div_q;
                            2'd1: qy_reg <= div_q;
                            default: ;
                        endcase
                        if (axis_reg == 2'd2) begin
                            state_reg <= ST_OUT;
                        end else begin
                            axis_reg  <= axis_reg + 2'd1;
                            div_start <= 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    if (!mv_reg) begin
                        mv_reg <= 1'b1;
                        if (used_reg == 7'd0) begin
                            res_reg <= '0;
                        end else begin
                            res_reg <= '{qx_reg, qy_reg, div_q, used_reg};
                        end
                        state_reg <= ST_FILL;
                    end
                end
                default: state_reg <= ST_FILL;
            endcase
        end
    end

    // match counters move with their samples, so after a full circuit of the ring every
    // sample has met every other at the tail and sits back in its own cell

    always_comb begin
        unique case (paddr[3:2])
            RegChange: prdata = {16'd0, chg_reg};
            RegAgree:  prdata = {16'd0, agr_reg};
            RegMin:    prdata = {25'd0, min_reg};
            default:   prdata = 32'd0;
        endcase
    end

    assign pready  = 1'b1;
    assign m_valid = mv_reg;
    assign m_data  = res_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_FILL |-> !s_ready) else $error("accept while busy");
    a_used_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.used_count <= 7'(Window)) else $error("used too big");
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < IdxW'(Window)) else $error("fill out of range");

endmodule

[hw/rtl/cfpa_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpa_cell
// One window entry: holds a sample, passes it to its neighbor, and counts
// how many broadcast z values agree with the z of the sample it holds.
// ----------------------------------------------------------------------------
module cfpa_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfpa_pkg::cell_ctl_t ctl,
    input  cfpa_pkg::sample_t   prev_in,
    input  logic [6:0]          prev_match,
    input  logic signed [31:0]  bcast_z,
    input  logic [15:0]         agree_thr,
    output cfpa_pkg::sample_t   data_out,
    output logic [6:0]          match_out
);
    import cfpa_pkg::*;

    sample_t            data_reg;
    logic [6:0]         match_reg;
    logic [6:0]         match_next;
    logic signed [32:0] diff;
    logic [32:0]        z_gap;
    logic               hit;

    assign diff  = {data_reg.sample_z[31], data_reg.sample_z} - {bcast_z[31], bcast_z};
    assign z_gap = diff[32] ? 33'(-diff) : diff;
    assign hit   = ctl.count && (z_gap < {17'd0, agree_thr});

    // the count travels with its sample, bumped on the way out
    assign match_out = match_reg + {6'd0, hit};

    always_comb begin
        match_next = match_reg;
        if (ctl.clear) begin
            match_next = 7'd0;
        end else if (ctl.rotate) begin
            match_next = prev_match;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load || ctl.rotate) begin
            data_reg <= prev_in;
        end
        if (!aresetn) begin
            match_reg <= 7'd0;
        end else begin
            match_reg <= match_next;
        end
    end

    assign data_out = data_reg;

endmodule

[hw/rtl/cfpa_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpa_divider
// Restoring divider, one quotient bit a cycle, signed dividend truncated
// toward zero by a small unsigned divisor.
// ----------------------------------------------------------------------------
module cfpa_divider (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [cfpa_pkg::SumW-1:0]  dividend,
    input  logic [6:0]                        divisor,
    output logic                              done,
    output logic signed [31:0]                quotient
);
    import cfpa_pkg::*;

    localparam int CntW = $clog2(SumW + 1);

    logic [SumW-1:0] quo_reg;
    logic [7:0]      rem_reg;
    logic [CntW-1:0] cnt_reg;
    logic            neg_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [7:0]      trial;

    assign trial = {rem_reg[6:0], quo_reg[SumW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(SumW);
                neg_reg  <= dividend[SumW-1];
                quo_reg  <= dividend[SumW-1] ? SumW'(-dividend) : dividend;
                rem_reg  <= 8'd0;
            end else if (busy_reg) begin
                if (trial >= {1'b0, divisor}) begin
                    rem_reg <= trial - {1'b0, divisor};
                    quo_reg <= {quo_reg[SumW-2:0], 1'b1};
                end else begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[SumW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - CntW'(1);
                if (cnt_reg == CntW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? 32'(-quo_reg) : quo_reg[31:0];

endmodule

[bench/cfpa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpa_checker
// Watches the sample and result channels and the register port, predicts the
// window averages and compares every result beat field by field.
// ----------------------------------------------------------------------------
module cfpa_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  cfpa_pkg::sample_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  cfpa_pkg::result_t  m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 errors,
    output int                 pending
);
    import cfpa_pkg::*;

    logic [15:0] chg_thr;
    logic [15:0] agr_thr;
    logic [6:0]  min_agr;
    logic signed [31:0] win_x [Window];
    logic signed [31:0] win_y [Window];
    logic signed [31:0] win_z [Window];
    int          fill;
    result_t     mean_q[$];

    assign pending = mean_q.size();

    function automatic logic [32:0] zgap(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        return d < 0 ? 33'(-d) : 33'(d);
    endfunction

    // store the sample if it moved enough; on a full window queue the mean
    task automatic take_sample(sample_t s);
        logic signed [63:0] sx, sy, sz;
        int used, m;
        result_t r;
        if (fill != 0 && zgap(s.sample_z, win_z[fill-1]) <= {17'd0, chg_thr})
            return;
        win_x[fill] = s.sample_x;
        win_y[fill] = s.sample_y;
        win_z[fill] = s.sample_z;
        fill++;
        if (fill < Window)
            return;
        fill = 0;
        sx = 0; sy = 0; sz = 0; used = 0;
        for (int i = 0; i < Window; i++) begin
            m = 0;
            for (int j = 0; j < Window; j++)
                if (zgap(win_z[i], win_z[j]) < {17'd0, agr_thr})
                    m++;
            if (m >= min_agr) begin
                sx += win_x[i];
                sy += win_y[i];
                sz += win_z[i];
                used++;
            end
        end
        r = '0;
        if (used != 0) begin
            r.mean_x = 32'(sx / used);
            r.mean_y = 32'(sy / used);
            r.mean_z = 32'(sz / used);
            r.used_count = 7'(used);
        end
        mean_q.push_back(r);
    endtask

    always @(posedge aclk) begin
        result_t exp_r;
        if (!aresetn) begin
            chg_thr = ChangeThrRst;
            agr_thr = AgreeThrRst;
            min_agr = MinAgreeRst;
            fill = 0;
            errors = 0;
            mean_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    RegChange: chg_thr = pwdata[15:0];
                    RegAgree:  agr_thr = pwdata[15:0];
                    RegMin:    min_agr = pwdata[6:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (mean_q.size() == 0) begin
                    $display("%0t unexpected result beat %h", $time, m_data);
                    errors++;
                end else begin
                    exp_r = mean_q.pop_front();
                    if (exp_r.mean_x !== m_data.mean_x) begin
                        $display("%0t mean_x exp %0d got %0d", $time, exp_r.mean_x, m_data.mean_x);
                        errors++;
                    end
                    if (exp_r.mean_y !== m_data.mean_y) begin
                        $display("%0t mean_y exp %0d got %0d", $time, exp_r.mean_y, m_data.mean_y);
                        errors++;
                    end
                    if (exp_r.mean_z !== m_data.mean_z) begin
                        $display("%0t mean_z exp %0d got %0d", $time, exp_r.mean_z, m_data.mean_z);
                        errors++;
                    end
                    if (exp_r.used_count !== m_data.used_count) begin
                        $display("%0t used_count exp %0d got %0d", $time,
                                 exp_r.used_count, m_data.used_count);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready)
                take_sample(s_data);
        end
    end
endmodule

[bench/tb_consensus_filtered_position_average.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_consensus_filtered_position_average
// Drives position samples in bursts under random result stalls and several
// register settings; the checker predicts and compares each result beat.
// ----------------------------------------------------------------------------
module tb_consensus_filtered_position_average;
    import cfpa_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    sample_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    result_t     m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          burst_left = 0;
    bit          hold_off = 1'b0;
    int          hold_cycles;
    logic signed [31:0] z_base;

    always #10 aclk = ~aclk;

    consensus_filtered_position_average DUT (.*);

    cfpa_checker u_checker (.*);

    initial begin
        #200ms;
        $display("Regression FAIL");
        $finish;
    end

    // receiver stall pattern, with one long hold-off when asked
    always @(negedge aclk) begin
        if (hold_off && hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles--;
        end else begin
            case ($urandom_range(0, 3))
                0: m_ready <= ($urandom_range(0, 3) == 0);
                1: m_ready <= 1'b1;
                default: m_ready <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // offer one sample, then wait for its acceptance; gaps come between bursts
    // valid drops only at a gap or in drain, so back-to-back beats stay high
    task automatic send_sample(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= '{x, y, z};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (150) @(negedge aclk);
    endtask

    // samples cluster around a base z (mode 0 is fully random, mode 2 mixes both) so agreement counts vary
    task automatic random_window(int n, int spread, int step_mode);
        logic signed [31:0] z;
        for (int i = 0; i < n; i++) begin
            case (step_mode)
                0: z = $urandom;
                1: z = z_base + $signed($urandom_range(0, 2 * spread)) - spread;
                default: z = (i % 3 == 0) ? $urandom : z_base
                             + $signed($urandom_range(0, 2 * spread)) - spread;
            endcase
            send_sample($urandom, $urandom, z);
        end
    endtask

    initial begin
        logic signed [31:0] ext;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, rejected repeats, wide z gap beyond 32 bits
        for (int i = 0; i < 22; i++) begin
            ext = (i % 2) ? 32'sh7fffffff : 32'sh80000000;
            send_sample(ext, ~ext, (i < 2) ? ext : ((i % 4 < 2) ? 32'sh80000000 + i
                                                     : 32'sh7fffffff - i));
        end
        drain();

        // register extremes: all qualify, none qualify, zero thresholds
        write_reg(RegChange, 32'hffff0000);
        write_reg(RegAgree, 32'h0000ffff);
        write_reg(RegMin, 32'd0);
        z_base = 0;
        random_window(40, 100000, 1);
        drain();
        write_reg(RegChange, 32'd0);
        write_reg(RegAgree, 32'd0);
        write_reg(RegMin, 32'd64);
        random_window(40, 5000, 1);
        drain();
        write_reg(RegMin, 32'd1);
        random_window(20, 5000, 1);
        drain();

        // long receiver hold-off while samples keep coming
        hold_cycles = 3000;
        hold_off = 1'b1;
        random_window(80, 20000, 1);
        hold_off = 1'b0;
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            write_reg(RegChange, $urandom_range(0, 1) ? $urandom_range(0, 200) : $urandom);
            write_reg(RegAgree, $urandom_range(0, 1) ? $urandom_range(100, 8000) : $urandom);
            write_reg(RegMin, $urandom_range(0, 3) ? $urandom_range(1, 20) : $urandom_range(0, 127));
            for (int w = 0; w < 13; w++) begin
                z_base = $urandom;
                random_window(20, $urandom_range(50, 6000), $urandom_range(0, 5) == 0 ? 0
                              : ($urandom_range(0, 3) == 0 ? 2 : 1));
            end
            drain();
        end
        write_reg(RegChange, 32'd66);
        write_reg(RegAgree, 32'd3277);
        write_reg(RegMin, 32'd15);
        z_base = 32'sh00010000;
        random_window(60, 3000, 1);
        drain();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
